// File: src/abff_pkg.sv
// ----------------------------------------------------------------------------
// abff_pkg: shared types and constants for the allocation bitmap
// Mode codes, word and index widths, controller state type and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package abff_pkg;

    // Default bitmap geometry
    localparam int ABFF_WORD_BITS = 64;
    localparam int ABFF_WORDS     = 64;

    // Fixed field widths
    localparam int MODE_W = 3;
    localparam int IDX_W  = 12;
    localparam int NUMB_W = 13;
    localparam int BASE_W = 14;

    localparam logic [NUMB_W-1:0] NUM_BITS_RESET = 13'd4096;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_TEST      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_ALL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND_SET  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FIND_CLR  = 3'd6;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ACCESS,
        ST_MODIFY,
        ST_FILL,
        ST_SCAN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic init;
        logic capture;
        logic decode;
        logic access;
        logic modify;
        logic fill;
        logic scan;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic              init_last;
        logic              more;
        logic              scan_done;
        logic [MODE_W-1:0] mode;
    } t_sts;

endpackage

`default_nettype wire

// File: src/abff_ctrl.sv
// ----------------------------------------------------------------------------
// abff_ctrl: sequencing state machine
// Steps each transaction through decode, word access, fill sweep or scan,
// and runs the pass that writes all ones to the bitmap after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module abff_ctrl
    import abff_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.mode)
                    MODE_SET_ALL, MODE_CLEAR_ALL: n_state = ST_FILL;
                    MODE_FIND_SET, MODE_FIND_CLR: n_state = ST_SCAN;
                    default:                      n_state = ST_ACCESS;
                endcase
            end
            ST_ACCESS: n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_IDLE;
            ST_FILL: begin
                if (!i_sts.more) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_INIT:   o_cmd.init = 1'b1;
            ST_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            ST_DECODE: o_cmd.decode = 1'b1;
            ST_ACCESS: o_cmd.access = 1'b1;
            ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                o_cmd.finish = 1'b1;
            end
            ST_FILL: begin
                o_cmd.fill   = 1'b1;
                o_cmd.finish = !i_sts.more;
            end
            ST_SCAN: begin
                o_cmd.scan   = 1'b1;
                o_cmd.finish = i_sts.scan_done;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: src/abff_dpath.sv
// ----------------------------------------------------------------------------
// abff_dpath: bitmap store, word counters and result registers
// Holds the bitmap memory and the bit count, splits the bit index into word
// and position, sweeps words for fills and finds, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module abff_dpath
    import abff_pkg::*;
#(
    parameter int WORD_BITS = ABFF_WORD_BITS,
    parameter int WORDS     = ABFF_WORDS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [IDX_W-1:0]  i_bit_index,
    input  wire logic              i_cfg_we,
    input  wire logic [NUMB_W-1:0] i_cfg_wdata,
    output logic                   o_done,
    output logic                   o_flag,
    output logic [IDX_W-1:0]       o_found_index,
    output logic                   o_index_error
);

    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW       = $clog2(WORD_BITS);
    localparam int CAP      = WORDS * WORD_BITS;
    localparam logic [BASE_W-1:0] CAP_CLIP =
        (CAP > 8191) ? BASE_W'(8191) : BASE_W'(CAP);
    // Reciprocal for the word split: exact for every 12-bit index
    localparam int RECIP_K  = 18;
    localparam int RECIP    = ((2 ** RECIP_K) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W   = IDX_W + 16;
    localparam logic [BASE_W-1:0] WB_STEP = BASE_W'(WORD_BITS);

    function automatic logic [PW-1:0] enc_onehot(input logic [WORD_BITS-1:0] oh);
        logic [PW-1:0] e;
        e = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                e = e | PW'(i);
            end
        end
        return e;
    endfunction

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [NUMB_W-1:0] r_num;
    logic [MODE_W-1:0] r_mode;
    logic [IDX_W-1:0]  r_bi;
    logic [AW-1:0]     r_w;
    logic [PW-1:0]     r_pos;
    logic              r_inr;
    logic [AW:0]       r_cnt;
    logic [BASE_W-1:0] r_base;
    logic [BASE_W-1:0] r_rd_base;
    logic              r_pend;
    logic              r_done;
    logic              r_flag;
    logic [IDX_W-1:0]  r_found;
    logic              r_err;

    logic [NUMB_W-1:0]    n_eff;
    logic [PROD_W-1:0]    prod;
    logic [IDX_W-1:0]     wbase;
    logic                 more;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] pos_bit;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;
    logic                 hit;
    logic [BASE_W-1:0]    hit_idx;
    logic                 hit_ok;
    logic                 n_flag;
    logic [IDX_W-1:0]     n_found;
    logic                 n_err;
    logic                 bit_wr;

    // Effective count: saturate at capacity
    assign n_eff = ({1'b0, r_num} > CAP_CLIP) ? CAP_CLIP[NUMB_W-1:0] : r_num;
    assign more  = r_base < {1'b0, n_eff};

    assign prod  = PROD_W'(r_bi) * PROD_W'(RECIP);
    assign wbase = IDX_W'(32'(r_w) * WORD_BITS);

    assign pos_bit = WORD_BITS'(1) << r_pos;
    assign cand    = (r_mode == MODE_FIND_SET) ? r_rdata : ~r_rdata;
    assign lowest  = cand & (~cand + WORD_BITS'(1));
    assign hit     = r_pend && (cand != '0);
    assign hit_idx = r_rd_base + BASE_W'(enc_onehot(lowest));
    assign hit_ok  = hit_idx < {1'b0, n_eff};
    assign bit_wr  = r_inr && ((r_mode == MODE_SET) || (r_mode == MODE_CLEAR));

    assign o_sts.init_last = (r_cnt == (AW+1)'(WORDS - 1));
    assign o_sts.more      = more;
    assign o_sts.scan_done = hit || (!r_pend && !more);
    assign o_sts.mode      = r_mode;

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = '1;
        mem_re    = 1'b0;
        mem_raddr = r_cnt[AW-1:0];
        if (i_cmd.init) begin
            mem_we = 1'b1;
        end else if (i_cmd.fill && more) begin
            mem_we    = 1'b1;
            mem_wdata = (r_mode == MODE_SET_ALL) ? '1 : '0;
        end else if (i_cmd.modify && bit_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_w;
            mem_wdata = (r_mode == MODE_SET) ? (r_rdata | pos_bit) : (r_rdata & ~pos_bit);
        end
        if (i_cmd.access && r_inr) begin
            mem_re    = 1'b1;
            mem_raddr = r_w;
        end else if (i_cmd.scan && more) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Result selection
    always_comb begin
        n_flag  = 1'b1;
        n_found = '0;
        n_err   = 1'b0;
        case (r_mode)
            MODE_TEST: begin
                n_flag = r_inr && r_rdata[r_pos];
                n_err  = !r_inr;
            end
            MODE_SET, MODE_CLEAR: begin
                n_err = !r_inr;
            end
            MODE_FIND_SET, MODE_FIND_CLR: begin
                n_flag  = hit && hit_ok;
                n_found = (hit && hit_ok) ? hit_idx[IDX_W-1:0] : '0;
            end
            default: n_flag = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= NUM_BITS_RESET;
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
            r_done <= i_cmd.finish;
            if (i_cmd.init) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_cmd.decode) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if ((i_cmd.fill || i_cmd.scan) && more) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end
            if (i_cmd.scan) begin
                r_pend <= more;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_bi   <= i_bit_index;
        end
        if (i_cmd.decode) begin
            r_w    <= prod[RECIP_K +: AW];
            r_inr  <= {1'b0, r_bi} < n_eff;
            r_base <= '0;
        end else if ((i_cmd.fill || i_cmd.scan) && more) begin
            r_base <= r_base + WB_STEP;
        end
        if (i_cmd.access) begin
            r_pos <= PW'(r_bi - wbase);
        end
        if (i_cmd.scan) begin
            r_rd_base <= r_base;
        end
        if (i_cmd.finish) begin
            r_flag  <= n_flag;
            r_found <= n_found;
            r_err   <= n_err;
        end
    end

    assign o_done        = r_done;
    assign o_flag        = r_flag;
    assign o_found_index = r_found;
    assign o_index_error = r_err;

    // A result strobe never lasts more than one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held");

    // No write to the bitmap while a find sweeps it
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> !mem_we)
        else $error("bitmap written during scan");

    // Index error only for single-bit operations
    a_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_err) |->
            ((r_mode == MODE_TEST) || (r_mode == MODE_SET) || (r_mode == MODE_CLEAR)))
        else $error("index error on a word operation");

    // A non-zero found index comes only with a hit
    a_found_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_found != '0)) |-> r_flag)
        else $error("found index without hit");

endmodule

`default_nettype wire

// File: src/allocation_bitmap_find_first_unit.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first_unit: allocation bitmap with find-first
// Bitmap of WORDS x WORD_BITS bits, all ones after reset, with test, set,
// clear, set all, clear all, find lowest set and find lowest clear.
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  ---------------------
//  command   i_mode, i_bit_index                        start && !busy
//  result    o_flag, o_found_index, o_index_error       o_done, one cycle
//  config    i_cfg_wdata (num_bits)                     i_cfg_we
//
//  Steps: test, set and clear run from acceptance to o_done through
//    decode, word read, and modify with a write for set and clear. Set
//    all and clear all sweep ceil(n / WORD_BITS) words and a find up to
//    that many, the bitmap memory taking one word a cycle.
//  Reset: an initial pass writes all ones to all WORDS words, one a cycle,
//    and busy stays high until the pass is over.
//  Stalls: none; the receiver takes every result in its strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module allocation_bitmap_find_first_unit
    import abff_pkg::*;
#(
    parameter int WORD_BITS = ABFF_WORD_BITS,
    parameter int WORDS     = ABFF_WORDS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command transaction
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [IDX_W-1:0]  i_bit_index,
    // configuration: num_bits
    input  wire logic              i_cfg_we,
    input  wire logic [NUMB_W-1:0] i_cfg_wdata,
    // result transaction
    output logic                   o_done,
    output logic                   o_flag,
    output logic [IDX_W-1:0]       o_found_index,
    output logic                   o_index_error
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: decides which datapath step runs each cycle
    abff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Bitmap memory, sweep counters and result registers
    abff_dpath #(
        .WORD_BITS (WORD_BITS),
        .WORDS     (WORDS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_bit_index   (i_bit_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_flag        (o_flag),
        .o_found_index (o_found_index),
        .o_index_error (o_index_error)
    );

endmodule

`default_nettype wire
